/* hdl/invc_pkg.sv */
// Shared constants and types of the inversion counter.
package invc_pkg;

  localparam int unsigned MaxItemsDef = 1024;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned InvW        = 19;

  localparam logic [InvW-1:0] InvMax = '1;

  typedef struct packed {
    logic valid;
    logic last;
    logic placed;
  } tok_ctrl_t;

endpackage

/* hdl/invc_if.sv */
// Input and result channel interfaces of the inversion counter.
interface invc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [invc_pkg::ValueW-1:0]  value;
  logic                                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface invc_out_if;
  logic                            valid;
  logic                            ready;
  logic [invc_pkg::InvW-1:0]       inversions;
  logic                            overflow;

  modport source (output valid, output inversions, output overflow, input ready);
  modport sink   (input valid, input inversions, input overflow, output ready);
endinterface

/* hdl/invc_cell.sv */
// One cell of the chain: holds one element and counts greater ones for passing tokens.
module invc_cell #(
  parameter int unsigned CntW = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  invc_pkg::tok_ctrl_t                ctrl_i,
  input  logic signed [invc_pkg::ValueW-1:0] value_i,
  input  logic [CntW-1:0]                    count_i,
  output invc_pkg::tok_ctrl_t                ctrl_o,
  output logic signed [invc_pkg::ValueW-1:0] value_o,
  output logic [CntW-1:0]                    count_o
);

  logic                               held_q, held_d;
  logic signed [invc_pkg::ValueW-1:0] elem_q;
  invc_pkg::tok_ctrl_t                ctrl_q, ctrl_d;
  logic signed [invc_pkg::ValueW-1:0] value_q;
  logic [CntW-1:0]                    count_q, count_d;
  logic                               greater;
  logic                               store;

  always_comb begin
    greater = held_q && (elem_q > value_i);
    store   = ctrl_i.valid && !held_q && !ctrl_i.placed && !ctrl_i.last;
    count_d = count_i + CntW'(greater);
    ctrl_d  = ctrl_i;
    ctrl_d.placed = ctrl_i.placed | (ctrl_i.valid && !held_q);
    held_d  = held_q;
    if (ctrl_i.valid) begin
      if (ctrl_i.last) begin
        held_d = 1'b0;
      end else if (store) begin
        held_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      ctrl_q <= '0;
    end else if (en_i) begin
      held_q <= held_d;
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_i;
      count_q <= count_d;
      if (store) begin
        elem_q <= value_i;
      end
    end
  end

  assign ctrl_o  = ctrl_q;
  assign value_o = value_q;
  assign count_o = count_q;

endmodule

/* hdl/invc_acc.sv */
// Tail of the chain: running total, overflow flag and result register.
module invc_acc #(
  parameter int unsigned CntW = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  invc_pkg::tok_ctrl_t ctrl_i,
  input  logic [CntW-1:0]     count_i,
  invc_out_if.source          out_o,
  output logic                en_o
);

  localparam int unsigned SumW =
      ((CntW > invc_pkg::InvW) ? CntW : invc_pkg::InvW) + 1;

  logic [invc_pkg::InvW-1:0] total_q, total_d;
  logic                      ovf_q, ovf_d;
  logic                      out_valid_q;
  logic [invc_pkg::InvW-1:0] out_inv_q;
  logic                      out_ovf_q;
  logic [SumW-1:0]           sum;
  logic                      tok;

  assign en_o = !(ctrl_i.valid && ctrl_i.last && out_valid_q && !out_o.ready);
  assign tok  = en_o && ctrl_i.valid;

  always_comb begin
    sum     = SumW'(total_q) + SumW'(count_i);
    total_d = total_q;
    ovf_d   = ovf_q;
    if (ctrl_i.placed) begin
      if (sum > SumW'(invc_pkg::InvMax)) begin
        total_d = invc_pkg::InvMax;
      end else begin
        total_d = sum[invc_pkg::InvW-1:0];
      end
    end else begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (tok) begin
        if (ctrl_i.last) begin
          total_q     <= '0;
          ovf_q       <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          total_q <= total_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok && ctrl_i.last) begin
      out_inv_q <= total_d;
      out_ovf_q <= ovf_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inversions = out_inv_q;
  assign out_o.overflow   = out_ovf_q;

endmodule

/* hdl/inversion_counter_unit.sv */
// Top level of the inversion counter: input beat, cell chain and result stage.
//
// Counts pairs i<j with a[i] > a[j] over a stream of signed 32-bit values closed by
// a beat with last set. While the input is not stalled, one beat is taken every cycle
// and each beat walks a chain of MAX_ITEMS cells, one cell per cycle, counting stored
// elements greater than itself and settling into the first free cell. The result is
// registered once the last beat has passed every cell, and the next array may follow
// in the very next cycle. The input stalls only while a last beat sits at the end of
// the chain and the previous result has not been taken. Beats past MAX_ITEMS are
// dropped and flagged by overflow; the total saturates at 2^19 - 1.
module inversion_counter_unit #(
  parameter int unsigned MAX_ITEMS = invc_pkg::MaxItemsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  invc_in_if.sink    in_i,
  invc_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS);

  invc_pkg::tok_ctrl_t                ctrl_w  [MAX_ITEMS+1];
  logic signed [invc_pkg::ValueW-1:0] value_w [MAX_ITEMS+1];
  logic [CntW-1:0]                    count_w [MAX_ITEMS+1];
  logic                               en;

  assign in_i.ready      = en;
  assign ctrl_w[0].valid  = in_i.valid;
  assign ctrl_w[0].last   = in_i.last;
  assign ctrl_w[0].placed = 1'b0;
  assign value_w[0]       = in_i.value;
  assign count_w[0]       = '0;

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    invc_cell #(
      .CntW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctrl_i  (ctrl_w[k]),
      .value_i (value_w[k]),
      .count_i (count_w[k]),
      .ctrl_o  (ctrl_w[k+1]),
      .value_o (value_w[k+1]),
      .count_o (count_w[k+1])
    );
  end

  invc_acc #(
    .CntW (CntW)
  ) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_w[MAX_ITEMS]),
    .count_i (count_w[MAX_ITEMS]),
    .out_o   (out_o),
    .en_o    (en)
  );

endmodule

/* tb/inversion_counter_unit_tb.sv */
// Self-checking testbench of the inversion counter: streamed arrays, predicted totals.
module inversion_counter_unit_tb;

  localparam int unsigned MaxItems    = invc_pkg::MaxItemsDef;
  localparam int unsigned StallMax    = 19;
  localparam int unsigned IdleLimit   = 4 * (MaxItems + 2 * StallMax + 8);
  localparam int unsigned ItemsTarget = 1700;
  localparam int unsigned SmallItems  = ItemsTarget - (MaxItems + 1) - 18;

  typedef logic signed [invc_pkg::ValueW-1:0] elem_t;

  typedef struct packed {
    logic [invc_pkg::InvW-1:0] inversions;
    logic                      overflow;
  } total_t;

  typedef enum int {
    StyleFull,
    StyleNarrow,
    StyleCorner,
    StyleSparse,
    StyleFalling,
    StyleRamp
  } elem_style_e;

  class inversion_book;
    elem_t       held_vals [MaxItems];
    int unsigned held_cnt;
    int unsigned run_sum;
    bit          dropped;
    total_t      totals_due [$];
    int          errors;

    function new();
      held_cnt = 0;
      run_sum  = 0;
      dropped  = 1'b0;
      errors   = 0;
    endfunction

    task report_mismatch(input string what);
      if (errors < 100) $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void note_element(input elem_t v, input logic is_last);
      int unsigned greater;
      total_t      t;
      greater = 0;
      if (held_cnt < MaxItems) begin
        for (int unsigned k = 0; k < held_cnt; k++) begin
          if (held_vals[k] > v) greater++;
        end
        if (run_sum + greater > invc_pkg::InvMax) run_sum = invc_pkg::InvMax;
        else run_sum = run_sum + greater;
        held_vals[held_cnt] = v;
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (is_last) begin
        t.inversions = run_sum[invc_pkg::InvW-1:0];
        t.overflow   = dropped;
        totals_due   = {totals_due, t};
        held_cnt = 0;
        run_sum  = 0;
        dropped  = 1'b0;
      end
    endfunction

    task check_total(input logic [invc_pkg::InvW-1:0] inv, input logic ovf);
      total_t t;
      if (totals_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: inversions=%0d overflow=%0b",
                                  inv, ovf));
      end else begin
        t = totals_due.pop_front();
        if (inv !== t.inversions)
          report_mismatch($sformatf("inversions got %0d want %0d", inv, t.inversions));
        if (ovf !== t.overflow)
          report_mismatch($sformatf("overflow got %0b want %0b", ovf, t.overflow));
      end
    endtask

    function int pending();
      return totals_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  invc_in_if  in_if ();
  invc_out_if out_if ();

  inversion_counter_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  inversion_book book = new();
  bit            in_burst;
  int unsigned   idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(input bit burst);
    if (burst || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, StallMax);
  endfunction

  function automatic elem_t draw_value(input elem_style_e style, input int unsigned idx,
                                       input elem_t base);
    elem_t v;
    case (style)
      StyleFull:   v = elem_t'($urandom);
      StyleNarrow: v = elem_t'($urandom_range(0, 8)) - elem_t'(4);
      StyleCorner: begin
        case ($urandom_range(0, 3))
          0:       v = elem_t'(32'h8000_0000);
          1:       v = elem_t'(32'h7fff_ffff);
          2:       v = '0;
          default: v = '1;
        endcase
      end
      StyleSparse: begin
        v = elem_t'($urandom_range(0, 15)) <<< $urandom_range(0, 28);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      StyleFalling: v = base - elem_t'(idx * $urandom_range(0, 3));
      default:      v = base - elem_t'(idx);
    endcase
    return v;
  endfunction

  task automatic send_beat(input elem_t v, input logic is_last);
    int unsigned gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.last  <= is_last;
    do @(posedge clk_i); while (!in_if.ready);
    book.note_element(v, is_last);
  endtask

  task automatic send_array(input int unsigned len, input elem_style_e style);
    elem_t base;
    base = elem_t'($urandom);
    if (style == StyleRamp) base = elem_t'(32'h7fff_ffff);
    in_burst = ($urandom_range(0, 2) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      send_beat(draw_value(style, i, base), i == len - 1);
    end
  endtask

  initial begin : stimulus
    elem_t       dir_vals [18] = '{
      elem_t'(32'h8000_0000),
      elem_t'(32'h7fff_ffff), elem_t'(32'h8000_0000),
      elem_t'(32'h8000_0000), elem_t'(32'h7fff_ffff),
      elem_t'(5), elem_t'(5),
      elem_t'(3), elem_t'(1), elem_t'(2),
      elem_t'(-1), elem_t'(0), elem_t'(-1), elem_t'(0),
      elem_t'(0), elem_t'(-1), elem_t'(1), elem_t'(-2)
    };
    bit          dir_last [18] = '{1, 0, 1, 0, 1, 0, 1, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
    int unsigned sent;
    int unsigned len;
    bit          big_done;
    elem_style_e style;

    rst_ni       = 1'b0;
    in_if.valid  <= 1'b0;
    in_if.value  <= '0;
    in_if.last   <= 1'b0;
    in_burst     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 18; i++) send_beat(dir_vals[i], dir_last[i]);

    sent     = 0;
    big_done = 1'b0;
    while (sent < SmallItems) begin
      if (!big_done && $urandom_range(0, 60) == 0) begin
        send_array(MaxItems + 1, StyleRamp);
        big_done = 1'b1;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        style = elem_style_e'($urandom_range(StyleFull, StyleFalling));
        send_array(len, style);
        sent += len;
      end
    end
    if (!big_done) send_array(MaxItems + 1, StyleRamp);
    in_if.valid <= 1'b0;

    while (book.pending() != 0) @(posedge clk_i);
    repeat (MaxItems + 40) @(posedge clk_i);
    if (book.pending() != 0) book.report_mismatch("totals still pending at end of run");

    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    out_if.ready <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!out_if.valid || !out_if.ready);
      book.check_total(out_if.inversions, out_if.overflow);
      gap = draw_gap($urandom_range(0, 2) == 0);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
